// ===== design/hcbp_pkg.sv =====
// Shared constants, operation codes and controller/datapath interface types.
package hcbp_pkg;

   localparam int TABLE_ENTRIES  = 256;
   localparam int SYMBOL_BITS    = 21;
   localparam int ENTRY_IDX_BITS = 8;
   localparam int CODE_BITS      = 32;
   localparam int LEN_BITS       = 6;
   localparam int OP_BITS        = 2;
   localparam int BYTE_BITS      = 8;
   localparam int ACC_BITS       = 32;
   localparam int WINDOW_BITS    = 2 * ACC_BITS;
   localparam int TOTAL_BITS     = $clog2(WINDOW_BITS + 1);
   localparam int LANES          = 8;
   localparam int LANE_BITS      = $clog2(LANES);
   localparam int ROWS           = TABLE_ENTRIES / LANES;
   localparam int ROW_BITS       = $clog2(ROWS);
   localparam int TABLE_IDX_BITS = $clog2(TABLE_ENTRIES);

   localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_FLUSH  = 2'd2;

   typedef struct packed {
      logic capture;
      logic write;
      logic scan_step;
      logic fetch;
      logic append;
      logic emit;
      logic miss;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
      logic more;
      logic last;
   } status_type;

endpackage

// ===== design/hcbp_ctrl.sv =====
// Controller state machine sequencing load, table scan, append and byte output.
module hcbp_ctrl import hcbp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [OP_BITS-1:0]   req_operation,
   input  status_type           stat,
   output cmd_type              cmd,
   output logic                 busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_FETCH,
      ST_APPEND,
      ST_CHECK,
      ST_EMIT,
      ST_MISS
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_operation)
                  OP_LOAD:   state_in = ST_WRITE;
                  OP_ENCODE: state_in = ST_SCAN;
                  OP_FLUSH:  state_in = ST_CHECK;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit) begin
               state_in = ST_FETCH;
            end else if (stat.exhausted) begin
               state_in = ST_MISS;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_APPEND;
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.more ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (stat.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_MISS: begin
            cmd.miss = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// ===== design/hcbp_datapath.sv =====
// Datapath: code table, row-wise symbol scan, bit window and result registers.
module hcbp_datapath import hcbp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                stat,
   input  logic [OP_BITS-1:0]        req_operation,
   input  logic [ENTRY_IDX_BITS-1:0] req_entry_index,
   input  logic [SYMBOL_BITS-1:0]    req_symbol,
   input  logic [CODE_BITS-1:0]      req_code_bits,
   input  logic [LEN_BITS-1:0]       req_code_length,
   output logic                      rsp_valid,
   output logic [BYTE_BITS-1:0]      rsp_out_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_symbol_missing,
   output logic                      rsp_last
);

   // captured item
   logic [OP_BITS-1:0]        op_ff;
   logic [ENTRY_IDX_BITS-1:0] idx_ff;
   logic [SYMBOL_BITS-1:0]    key_ff;
   logic [CODE_BITS-1:0]      code_ld_ff;
   logic [LEN_BITS-1:0]       len_ld_ff;

   // table storage
   logic [SYMBOL_BITS-1:0]    sym_mem  [ROWS][LANES];
   logic [CODE_BITS-1:0]      code_mem [TABLE_ENTRIES];
   logic [LEN_BITS-1:0]       len_mem  [TABLE_ENTRIES];
   logic [LANES-1:0]          valid_ff [ROWS];

   // scan pipeline
   logic [ROW_BITS-1:0]       rd_row_ff;
   logic [ROW_BITS-1:0]       cmp_row_ff;
   logic                      cmp_valid_ff;
   logic [SYMBOL_BITS-1:0]    rdata_ff [LANES];
   logic [LANES-1:0]          vrow_ff;
   logic [TABLE_IDX_BITS-1:0] hit_idx_ff;
   logic [LANES-1:0]          match;
   logic [LANE_BITS-1:0]      hit_lane;

   // fetched entry and bit window (held bits left aligned)
   logic [CODE_BITS-1:0]      code_rd_ff;
   logic [LEN_BITS-1:0]       len_rd_ff;
   logic [WINDOW_BITS-1:0]    window_ff;
   logic [TOTAL_BITS-1:0]     total_ff;

   logic                      rsp_valid_ff;
   logic [BYTE_BITS-1:0]      rsp_byte_ff;
   logic                      rsp_bvalid_ff;
   logic                      rsp_missing_ff;
   logic                      rsp_last_ff;

   logic [TABLE_IDX_BITS-1:0] wr_idx;
   logic [ROW_BITS-1:0]       wr_row;
   logic [LANE_BITS-1:0]      wr_lane;
   logic                      wr_in_range;
   logic [LEN_BITS-1:0]       len_clamped;
   logic [CODE_BITS:0]        len_mask;
   logic [TOTAL_BITS-1:0]     sum_total;
   logic [TOTAL_BITS-1:0]     shamt;
   logic [WINDOW_BITS-1:0]    code_placed;
   logic                      is_flush;
   logic [TOTAL_BITS-1:0]     total_next_emit;

   assign wr_idx      = idx_ff[TABLE_IDX_BITS-1:0];
   assign wr_row      = wr_idx[TABLE_IDX_BITS-1:LANE_BITS];
   assign wr_lane     = wr_idx[LANE_BITS-1:0];
   assign wr_in_range = ({1'b0, idx_ff} < (ENTRY_IDX_BITS+1)'(TABLE_ENTRIES));
   assign len_clamped = (len_ld_ff > LEN_BITS'(CODE_BITS)) ? LEN_BITS'(CODE_BITS) : len_ld_ff;
   assign len_mask    = ((CODE_BITS+1)'(1) << len_clamped) - (CODE_BITS+1)'(1);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_operation;
         idx_ff     <= req_entry_index;
         key_ff     <= req_symbol;
         code_ld_ff <= req_code_bits;
         len_ld_ff  <= req_code_length;
      end
   end

   // table write and registered reads
   always_ff @(posedge clock) begin
      if (cmd.write && wr_in_range) begin
         sym_mem[wr_row][wr_lane] <= key_ff;
         code_mem[wr_idx]         <= code_ld_ff & len_mask[CODE_BITS-1:0];
         len_mem[wr_idx]          <= len_clamped;
      end
      if (cmd.scan_step) begin
         rdata_ff   <= sym_mem[rd_row_ff];
         vrow_ff    <= valid_ff[rd_row_ff];
         cmp_row_ff <= rd_row_ff;
      end
      if (cmd.fetch) begin
         code_rd_ff <= code_mem[hit_idx_ff];
         len_rd_ff  <= len_mem[hit_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            valid_ff[r] <= '0;
         end
      end else if (cmd.write && wr_in_range) begin
         valid_ff[wr_row][wr_lane] <= 1'b1;
      end
   end

   // lowest matching lane of the compared row
   always_comb begin
      hit_lane = '0;
      for (int l = LANES - 1; l >= 0; l--) begin
         match[l] = vrow_ff[l] && (rdata_ff[l] == key_ff);
         if (match[l]) begin
            hit_lane = LANE_BITS'(l);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_row_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_step;
         if (cmd.capture) begin
            rd_row_ff <= '0;
         end else if (cmd.scan_step) begin
            rd_row_ff <= rd_row_ff + ROW_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stat.hit) begin
         hit_idx_ff <= {cmp_row_ff, hit_lane};
      end
   end

   // place the new code right below the held bits
   assign sum_total   = total_ff + TOTAL_BITS'(len_rd_ff);
   assign shamt       = TOTAL_BITS'(WINDOW_BITS) - sum_total;
   assign code_placed = {{(WINDOW_BITS-CODE_BITS){1'b0}}, code_rd_ff} << shamt;

   assign is_flush        = (op_ff == OP_FLUSH);
   assign total_next_emit = (total_ff > TOTAL_BITS'(BYTE_BITS)) ?
                            total_ff - TOTAL_BITS'(BYTE_BITS) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         total_ff  <= '0;
      end else if (cmd.append) begin
         window_ff <= window_ff | code_placed;
         total_ff  <= sum_total;
      end else if (cmd.emit) begin
         window_ff <= window_ff << BYTE_BITS;
         total_ff  <= total_next_emit;
      end
   end

   always_comb begin
      stat.hit       = cmp_valid_ff && (|match);
      stat.exhausted = cmp_valid_ff && !(|match) && (cmp_row_ff == ROW_BITS'(ROWS - 1));
      if (is_flush) begin
         stat.more = (total_ff != '0);
         stat.last = (total_ff <= TOTAL_BITS'(BYTE_BITS));
      end else begin
         stat.more = (total_ff > TOTAL_BITS'(ACC_BITS));
         stat.last = (total_ff <= TOTAL_BITS'(ACC_BITS + BYTE_BITS));
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit || cmd.miss;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff    <= window_ff[WINDOW_BITS-1 -: BYTE_BITS];
         rsp_bvalid_ff  <= 1'b1;
         rsp_missing_ff <= 1'b0;
         rsp_last_ff    <= stat.last;
      end else if (cmd.miss) begin
         rsp_byte_ff    <= '0;
         rsp_bvalid_ff  <= 1'b0;
         rsp_missing_ff <= 1'b1;
         rsp_last_ff    <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_byte_valid     = rsp_bvalid_ff;
   assign rsp_symbol_missing = rsp_missing_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ===== design/huffman_code_bit_packer_unit.sv =====
// Top level of the code bit packer: controller plus datapath.
//
// Command channel: present req_* with start high; the item is taken at an
// edge where busy is low. operation selects load (write one table slot),
// encode (look a symbol up and pack its code) or flush (emit held bits,
// last byte zero padded, then clear).
// Result channel: each result sits on rsp_* for one cycle with rsp_valid
// high; the receiver cannot hold it off. rsp_last marks an item's final one.
// Sequence: a load writes one table slot and returns to idle. An encode
// scans the symbol table eight slots per cycle over 32 rows; on a hit it
// fetches and appends the code, then emits 0 to 4 bytes, one per cycle.
// A missing symbol is flagged after all 32 rows are scanned, with a single
// flag result. A flush emits the held bits as bytes in the same way. After busy
// falls the next item may be taken in that same cycle.
// Reset clears the table valid bits, the held bits and the controller; slot
// contents are undefined until loaded.
module huffman_code_bit_packer_unit import hcbp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [OP_BITS-1:0]        req_operation,
   input  logic [ENTRY_IDX_BITS-1:0] req_entry_index,
   input  logic [SYMBOL_BITS-1:0]    req_symbol,
   input  logic [CODE_BITS-1:0]      req_code_bits,
   input  logic [LEN_BITS-1:0]       req_code_length,
   output logic                      rsp_valid,
   output logic [BYTE_BITS-1:0]      rsp_out_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_symbol_missing,
   output logic                      rsp_last
);

   cmd_type    cmd;
   status_type stat;

   hcbp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   hcbp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_entry_index    (req_entry_index),
      .req_symbol         (req_symbol),
      .req_code_bits      (req_code_bits),
      .req_code_length    (req_code_length),
      .rsp_valid          (rsp_valid),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_symbol_missing (rsp_symbol_missing),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== design/hcbp_checker.sv =====
// Port-level checker for the code bit packer, bound to the top level.
module hcbp_checker import hcbp_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [BYTE_BITS-1:0] rsp_out_byte,
   input logic                 rsp_byte_valid,
   input logic                 rsp_symbol_missing,
   input logic                 rsp_last
);

   // a missing symbol gives a lone flag result with no byte
   a_miss_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol_missing |-> rsp_last && !rsp_byte_valid && rsp_out_byte == '0)
      else $error("missing-symbol result malformed");

   // only an item's last result may appear once busy has dropped
   a_busy_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while idle");

   // bytes of one item come back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside an item's results");

   // a freshly taken item cannot answer in the very next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("result right after accept");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_byte_valid     (rsp_byte_valid),
   .rsp_symbol_missing (rsp_symbol_missing),
   .rsp_last           (rsp_last)
);
